FILE: design/ctb_pkg.sv
// shared types and constants of the cursor text buffer
package ctb_pkg;

    localparam int CMD_W  = 3;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_LEFT   = 3'd0,
        CMD_RIGHT  = 3'd1,
        CMD_BACK   = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PUT,
        ST_RD,
        ST_RWAIT,
        ST_FINISH
    } t_state;

endpackage

FILE: design/ctb_ram.sv
// generic single-write, single-read ram with registered read data
module ctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ctb_step_unit.sv
// shared address step and move counter used for every shift step
module ctb_step_unit #(
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic [AW-1:0] i_addr,
    input  logic [CW-1:0] i_cnt,
    input  logic          i_up,
    output logic [AW-1:0] o_fwd,
    output logic [AW-1:0] o_rev,
    output logic [CW-1:0] o_cnt_dec,
    output logic          o_cnt_zero
);

    logic [AW-1:0] w_inc;
    logic [AW-1:0] w_dec;

    assign w_inc      = i_addr + AW'(1);
    assign w_dec      = i_addr - AW'(1);
    // fwd is the next read address, rev the write address of this read
    assign o_fwd      = i_up ? w_inc : w_dec;
    assign o_rev      = i_up ? w_dec : w_inc;
    assign o_cnt_dec  = i_cnt - CW'(1);
    assign o_cnt_zero = (i_cnt == '0);

endmodule

FILE: design/cursor_text_buffer.sv
// top level of the cursor text buffer: sequencer, state registers and result register
// A line editor holding up to BUFFER_DEPTH bytes and a cursor between characters.
// Each input transfer carries a command (move left, move right, backspace, insert,
// read at position) and yields exactly one result transfer with the byte read
// (zero for other commands or out-of-range positions), the new length, the new
// cursor and a flag for an insert dropped on a full buffer. Items are handled one
// at a time and o_in_ready is low while an item is at work. Backspace and insert
// shift every byte between cursor and end of text through the single ram port
// pair, one byte per cycle. The ram needs no clearing after reset: only bytes
// at positions below the length are ever used. A finished result waits in an
// output register and the next item may be taken while it is still unclaimed;
// the following result then waits for the slot.
module cursor_text_buffer #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ctb_pkg::CMD_W-1:0]    i_command,
    input  logic [ctb_pkg::CHAR_W-1:0]   i_char_in,
    input  logic [ctb_pkg::POS_W-1:0]    i_read_pos,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ctb_pkg::CHAR_W-1:0]   o_char_out,
    output logic [ctb_pkg::LEN_W-1:0]    o_text_length,
    output logic [ctb_pkg::LEN_W-1:0]    o_cursor_out,
    output logic                         o_full_drop
);

    // address width, length/cursor width, and a common width for position compare
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = (LW > ctb_pkg::POS_W) ? LW : ctb_pkg::POS_W;

    ctb_pkg::t_state r_state, n_state;

    // editor state
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_cur, n_cur;

    // latched item
    logic [ctb_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [ctb_pkg::CHAR_W-1:0] r_char, n_char;
    logic [ctb_pkg::POS_W-1:0]  r_pos, n_pos;

    // shift engine
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic [LW-1:0] r_cnt, n_cnt;
    logic          r_wr_pend, n_wr_pend;
    logic [ctb_pkg::CHAR_W-1:0] r_rd_byte, n_rd_byte;

    // result register
    logic                        r_out_valid, n_out_valid;
    logic [ctb_pkg::CHAR_W-1:0]  r_o_char, n_o_char;
    logic [LW-1:0]               r_o_len, n_o_len;
    logic [LW-1:0]               r_o_cur, n_o_cur;
    logic                        r_o_drop, n_o_drop;

    // ram and step unit wiring
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [ctb_pkg::CHAR_W-1:0]  w_wdata;
    logic [AW-1:0]               w_raddr;
    logic [ctb_pkg::CHAR_W-1:0]  w_rdata;
    logic                        w_up;
    logic [AW-1:0]               w_fwd;
    logic [AW-1:0]               w_rev;
    logic [LW-1:0]               w_cnt_dec;
    logic                        w_cnt_zero;

    logic w_in_xfer;
    logic w_slot_free;
    logic w_full;

    assign o_in_ready  = (r_state == ctb_pkg::ST_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_full      = (r_len == LW'(BUFFER_DEPTH));
    // backspace walks upward through the text, insert walks downward
    assign w_up        = (r_cmd == ctb_pkg::CMD_BACK);

    ctb_ram #(
        .WIDTH (ctb_pkg::CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ctb_step_unit #(
        .AW (AW),
        .CW (LW)
    ) u_step (
        .i_addr     (r_rd_addr),
        .i_cnt      (r_cnt),
        .i_up       (w_up),
        .o_fwd      (w_fwd),
        .o_rev      (w_rev),
        .o_cnt_dec  (w_cnt_dec),
        .o_cnt_zero (w_cnt_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctb_pkg::ST_IDLE;
            r_len       <= '0;
            r_cur       <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cur       <= n_cur;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_char    <= n_char;
        r_pos     <= n_pos;
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        r_cnt     <= n_cnt;
        r_rd_byte <= n_rd_byte;
        r_o_char  <= n_o_char;
        r_o_len   <= n_o_len;
        r_o_cur   <= n_o_cur;
        r_o_drop  <= n_o_drop;
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_cur       = r_cur;
        n_cmd       = r_cmd;
        n_char      = r_char;
        n_pos       = r_pos;
        n_rd_addr   = r_rd_addr;
        n_wr_addr   = r_wr_addr;
        n_cnt       = r_cnt;
        n_wr_pend   = r_wr_pend;
        n_rd_byte   = r_rd_byte;
        n_out_valid = r_out_valid;
        n_o_char    = r_o_char;
        n_o_len     = r_o_len;
        n_o_cur     = r_o_cur;
        n_o_drop    = r_o_drop;
        w_we        = 1'b0;
        w_waddr     = r_wr_addr;
        w_wdata     = w_rdata;
        w_raddr     = r_rd_addr;

        // result leaves the output register
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ctb_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd     = i_command;
                    n_char    = i_char_in;
                    n_pos     = i_read_pos;
                    n_wr_pend = 1'b0;
                    // bytes between cursor and end of text take part in a shift
                    n_cnt     = r_len - r_cur;
                    case (i_command)
                        ctb_pkg::CMD_BACK: begin
                            // move [cur, len) down by one place
                            n_rd_addr = AW'(r_cur);
                            n_state   = (r_cur == '0) ? ctb_pkg::ST_FINISH
                                                      : ctb_pkg::ST_SHIFT;
                        end
                        ctb_pkg::CMD_INSERT: begin
                            // move [cur, len) up by one place, starting at the end
                            n_rd_addr = AW'(r_len - LW'(1));
                            n_state   = w_full ? ctb_pkg::ST_FINISH
                                               : ctb_pkg::ST_SHIFT;
                        end
                        ctb_pkg::CMD_READ: begin
                            n_state = ctb_pkg::ST_RD;
                        end
                        default: begin
                            n_state = ctb_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            ctb_pkg::ST_SHIFT: begin
                // write back the byte read in the previous cycle
                w_we    = r_wr_pend;
                w_waddr = r_wr_addr;
                w_wdata = w_rdata;
                if (!w_cnt_zero) begin
                    w_raddr   = r_rd_addr;
                    n_rd_addr = w_fwd;
                    n_wr_addr = w_rev;
                    n_cnt     = w_cnt_dec;
                    n_wr_pend = 1'b1;
                end else begin
                    n_wr_pend = 1'b0;
                    n_state   = (r_cmd == ctb_pkg::CMD_INSERT) ? ctb_pkg::ST_PUT
                                                               : ctb_pkg::ST_FINISH;
                end
            end

            ctb_pkg::ST_PUT: begin
                // new byte goes into the gap at the cursor
                w_we    = 1'b1;
                w_waddr = AW'(r_cur);
                w_wdata = r_char;
                n_state = ctb_pkg::ST_FINISH;
            end

            ctb_pkg::ST_RD: begin
                w_raddr = AW'(r_pos);
                n_state = ctb_pkg::ST_RWAIT;
            end

            ctb_pkg::ST_RWAIT: begin
                // positions at or past the end of text read as zero
                n_rd_byte = (PW'(r_pos) < PW'(r_len)) ? w_rdata : '0;
                n_state   = ctb_pkg::ST_FINISH;
            end

            ctb_pkg::ST_FINISH: begin
                if (w_slot_free) begin
                    n_o_char = '0;
                    n_o_drop = 1'b0;
                    case (r_cmd)
                        ctb_pkg::CMD_LEFT: begin
                            if (r_cur != '0) begin
                                n_cur = r_cur - LW'(1);
                            end
                        end
                        ctb_pkg::CMD_RIGHT: begin
                            if (r_cur < r_len) begin
                                n_cur = r_cur + LW'(1);
                            end
                        end
                        ctb_pkg::CMD_BACK: begin
                            if (r_cur != '0) begin
                                n_cur = r_cur - LW'(1);
                                n_len = r_len - LW'(1);
                            end
                        end
                        ctb_pkg::CMD_INSERT: begin
                            if (w_full) begin
                                n_o_drop = 1'b1;
                            end else begin
                                n_cur = r_cur + LW'(1);
                                n_len = r_len + LW'(1);
                            end
                        end
                        ctb_pkg::CMD_READ: begin
                            n_o_char = r_rd_byte;
                        end
                        default: begin
                        end
                    endcase
                    n_o_len     = n_len;
                    n_o_cur     = n_cur;
                    n_out_valid = 1'b1;
                    n_state     = ctb_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = ctb_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_out    = r_o_char;
    assign o_text_length = ctb_pkg::LEN_W'(r_o_len);
    assign o_cursor_out  = ctb_pkg::LEN_W'(r_o_cur);
    assign o_full_drop   = r_o_drop;

endmodule

FILE: design/ctb_checker.sv
// port-level checker of the cursor text buffer and its bind
module ctb_checker #(
    parameter int BUFFER_DEPTH = 1024
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [ctb_pkg::CMD_W-1:0]    i_command,
    input logic [ctb_pkg::CHAR_W-1:0]   i_char_in,
    input logic [ctb_pkg::POS_W-1:0]    i_read_pos,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [ctb_pkg::CHAR_W-1:0]   o_char_out,
    input logic [ctb_pkg::LEN_W-1:0]    o_text_length,
    input logic [ctb_pkg::LEN_W-1:0]    o_cursor_out,
    input logic                         o_full_drop
);

    // a stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_char_out) && $stable(o_text_length)
            && $stable(o_cursor_out) && $stable(o_full_drop))
        else $error("result changed while stalled");

    // one item at a time: ready drops after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after a transfer");

    // cursor never passes the end of text
    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_out <= o_text_length)
        else $error("cursor beyond end of text");

    // a dropped insert only happens on a full buffer
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_full_drop |->
            o_text_length == ctb_pkg::LEN_W'(BUFFER_DEPTH) && o_char_out == '0)
        else $error("drop flagged on a buffer that is not full");

    // no result straight out of reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind cursor_text_buffer ctb_checker #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctb_checker (.*);

FILE: tb/sv/cursor_text_buffer_tb.sv
// self-checking testbench of the cursor text buffer line editor
module cursor_text_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // geometry of the editor under test
    localparam int DEPTH = 1024;
    // length of the long line built part way through the run
    localparam int LONG_LEN = 120;
    // commands outside the defined set, the editor must leave its state alone
    localparam logic [ctb_pkg::CMD_W-1:0] CMD_UNDEF_FIRST = 3'd5;
    localparam logic [ctb_pkg::CMD_W-1:0] CMD_UNDEF_LAST  = 3'd7;
    // long receiver hold-off, enough to back up the result slot and the input
    localparam int HOLD_CYCLES = 400;
    // worst correct run: every item a full-depth shift plus both sides' longest
    // gaps, taken a few times over
    localparam int CYCLE_LIMIT = 8_000_000;

    typedef struct packed {
        logic [ctb_pkg::CHAR_W-1:0] ch;
        logic [ctb_pkg::LEN_W-1:0]  len;
        logic [ctb_pkg::LEN_W-1:0]  cur;
        logic                       drop;
    } t_editor_response;

    // scoreboard: tracks the text and cursor, queues the expected responses
    class t_editor_scoreboard;
        bit [ctb_pkg::CHAR_W-1:0] text_bytes [DEPTH];
        int                       text_len;
        int                       cursor_pos;
        t_editor_response         expected_responses [$];
        int                       mismatches;

        function new();
            text_len   = 0;
            cursor_pos = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // apply one accepted command to the tracked text
        function void note_command(logic [ctb_pkg::CMD_W-1:0] cmd,
                                   logic [ctb_pkg::CHAR_W-1:0] ch,
                                   logic [ctb_pkg::POS_W-1:0] pos);
            t_editor_response r;
            int k;
            r = '0;
            case (cmd)
                ctb_pkg::CMD_LEFT: begin
                    if (cursor_pos > 0) cursor_pos--;
                end
                ctb_pkg::CMD_RIGHT: begin
                    if (cursor_pos < text_len) cursor_pos++;
                end
                ctb_pkg::CMD_BACK: begin
                    if (cursor_pos > 0) begin
                        for (k = cursor_pos - 1; k + 1 < text_len; k++)
                            text_bytes[k] = text_bytes[k + 1];
                        text_len--;
                        cursor_pos--;
                    end
                end
                ctb_pkg::CMD_INSERT: begin
                    if (text_len >= DEPTH) begin
                        r.drop = 1'b1;
                    end else begin
                        for (k = text_len; k > cursor_pos; k--)
                            text_bytes[k] = text_bytes[k - 1];
                        text_bytes[cursor_pos] = ch;
                        text_len++;
                        cursor_pos++;
                    end
                end
                ctb_pkg::CMD_READ: begin
                    if (int'(pos) < text_len) r.ch = text_bytes[pos];
                end
                default: ;
            endcase
            r.len = ctb_pkg::LEN_W'(text_len);
            r.cur = ctb_pkg::LEN_W'(cursor_pos);
            expected_responses.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        // compare one result transfer against the oldest expectation
        function void check_response(t_editor_response act);
            t_editor_response exp_r;
            if (expected_responses.size() == 0) begin
                $error("result transfer with no command outstanding");
                mismatches++;
                return;
            end
            exp_r = expected_responses.pop_front();
            compare_field("char_out", exp_r.ch, act.ch);
            compare_field("text_length", exp_r.len, act.len);
            compare_field("cursor_out", exp_r.cur, act.cur);
            compare_field("full_drop", exp_r.drop, act.drop);
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [ctb_pkg::CMD_W-1:0]   i_command;
    logic [ctb_pkg::CHAR_W-1:0]  i_char_in;
    logic [ctb_pkg::POS_W-1:0]   i_read_pos;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [ctb_pkg::CHAR_W-1:0]  o_char_out;
    logic [ctb_pkg::LEN_W-1:0]   o_text_length;
    logic [ctb_pkg::LEN_W-1:0]   o_cursor_out;
    logic                        o_full_drop;

    t_editor_scoreboard sb;
    bit                 quiet;         // last part of the run: no idling on either side
    bit                 hold_request;  // sender asks the receiver for a long hold-off
    int                 cycle_count;

    cursor_text_buffer #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_char_in     (i_char_in),
        .i_read_pos    (i_read_pos),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_out    (o_char_out),
        .o_text_length (o_text_length),
        .o_cursor_out  (o_cursor_out),
        .o_full_drop   (o_full_drop)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** cursor_text_buffer: FAILED **");
            $finish;
        end
    end

    // monitor at the rising edge: results are checked before the command of the
    // same edge is noted, so an early result can never pop a fresh expectation
    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (o_out_valid && i_out_ready)
                sb.check_response(t_editor_response'{o_char_out, o_text_length,
                                                     o_cursor_out, o_full_drop});
            if (i_in_valid && o_in_ready)
                sb.note_command(i_command, i_char_in, i_read_pos);
        end
    end

    // receiver: random ready bursts, a long hold-off on request, none when quiet
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                // long stall counted here, the sender keeps offering meanwhile
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    // with valid still high, so back-to-back items keep it high
    task automatic send_cmd(logic [ctb_pkg::CMD_W-1:0] cmd, logic [ctb_pkg::CHAR_W-1:0] ch,
                            logic [ctb_pkg::POS_W-1:0] pos);
        i_in_valid = 1'b1;
        i_command  = cmd;
        i_char_in  = ch;
        i_read_pos = pos;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // random sender gap with valid low
    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    // hold the sender until every outstanding result has come back
    task automatic wait_all_results();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [ctb_pkg::CMD_W-1:0] CMD_LEN_UNDEF();
        return ctb_pkg::CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
    endfunction

    // random editing mix, kept to short lines so shifts stay cheap
    task automatic send_random();
        int                         r;
        logic [ctb_pkg::CMD_W-1:0]  cmd;
        logic [ctb_pkg::POS_W-1:0]  pos;
        r = $urandom_range(0, 99);
        if (r < 12)      cmd = ctb_pkg::CMD_LEFT;
        else if (r < 24) cmd = ctb_pkg::CMD_RIGHT;
        else if (r < 40) cmd = ctb_pkg::CMD_BACK;
        else if (r < 72) cmd = ctb_pkg::CMD_INSERT;
        else if (r < 94) cmd = ctb_pkg::CMD_READ;
        else             cmd = CMD_LEN_UNDEF();
        // long text: lean toward deleting
        if (sb.text_len >= 80 && cmd == ctb_pkg::CMD_INSERT && $urandom_range(0, 2) != 0)
            cmd = ctb_pkg::CMD_BACK;
        // reads mostly hit the text, the rest sweep the whole position range
        if (sb.text_len > 0 && $urandom_range(0, 3) != 0)
            pos = ctb_pkg::POS_W'($urandom_range(0, sb.text_len - 1));
        else
            pos = ctb_pkg::POS_W'($urandom_range(0, DEPTH - 1));
        send_cmd(cmd, ctb_pkg::CHAR_W'($urandom_range(0, 255)), pos);
    endtask

    task automatic run_random(int count, int hold_at);
        for (int i = 0; i < count; i++) begin
            maybe_idle();
            if (i == hold_at) hold_request = 1'b1;
            send_random();
        end
    endtask

    // grow a long line, edit it near the end, then shrink it back
    task automatic fill_and_shrink();
        while (sb.cursor_pos < sb.text_len)
            send_cmd(ctb_pkg::CMD_RIGHT, ctb_pkg::CHAR_W'($urandom),
                     ctb_pkg::POS_W'($urandom));
        // inserts at the end of text need no shifting
        while (sb.text_len < LONG_LEN) begin
            maybe_idle();
            if ($urandom_range(0, 31) == 0)
                send_cmd(ctb_pkg::CMD_READ, ctb_pkg::CHAR_W'($urandom),
                         ctb_pkg::POS_W'($urandom_range(0, DEPTH - 1)));
            send_cmd(ctb_pkg::CMD_INSERT, ctb_pkg::CHAR_W'($urandom_range(0, 255)),
                     ctb_pkg::POS_W'($urandom));
        end
        // long line: edits at the end and a few places before it
        send_cmd(ctb_pkg::CMD_INSERT, 8'h5A, ctb_pkg::POS_W'($urandom));
        send_cmd(ctb_pkg::CMD_INSERT, 8'hC3, ctb_pkg::POS_W'($urandom));
        send_cmd(ctb_pkg::CMD_READ, ctb_pkg::CHAR_W'($urandom), ctb_pkg::POS_W'(DEPTH - 1));
        send_cmd(ctb_pkg::CMD_READ, ctb_pkg::CHAR_W'($urandom), '0);
        send_cmd(ctb_pkg::CMD_RIGHT, ctb_pkg::CHAR_W'($urandom), ctb_pkg::POS_W'($urandom));
        repeat (3) send_cmd(ctb_pkg::CMD_LEFT, ctb_pkg::CHAR_W'($urandom),
                            ctb_pkg::POS_W'($urandom));
        send_cmd(ctb_pkg::CMD_INSERT, 8'h11, ctb_pkg::POS_W'($urandom));
        send_cmd(ctb_pkg::CMD_BACK, ctb_pkg::CHAR_W'($urandom), ctb_pkg::POS_W'($urandom));
        send_cmd(ctb_pkg::CMD_INSERT, 8'h22, ctb_pkg::POS_W'($urandom));
        send_cmd(ctb_pkg::CMD_INSERT, 8'h33, ctb_pkg::POS_W'($urandom));
        for (int i = 0; i < 12; i++)
            send_cmd(ctb_pkg::CMD_READ, ctb_pkg::CHAR_W'($urandom),
                     ctb_pkg::POS_W'($urandom_range(0, DEPTH - 1)));
        // back to a short line, deleting from the end
        while (sb.cursor_pos < sb.text_len)
            send_cmd(ctb_pkg::CMD_RIGHT, ctb_pkg::CHAR_W'($urandom),
                     ctb_pkg::POS_W'($urandom));
        while (sb.text_len > 32) begin
            maybe_idle();
            if ($urandom_range(0, 31) == 0)
                send_cmd(ctb_pkg::CMD_READ, ctb_pkg::CHAR_W'($urandom),
                         ctb_pkg::POS_W'($urandom_range(0, DEPTH - 1)));
            send_cmd(ctb_pkg::CMD_BACK, ctb_pkg::CHAR_W'($urandom),
                     ctb_pkg::POS_W'($urandom));
        end
    endtask

    initial begin
        sb           = new();
        quiet        = 1'b0;
        hold_request = 1'b0;
        cycle_count  = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = ctb_pkg::CMD_LEFT;
        i_char_in    = '0;
        i_read_pos   = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: edges of an empty buffer
        send_cmd(ctb_pkg::CMD_LEFT, 8'h00, '0);
        send_cmd(ctb_pkg::CMD_RIGHT, 8'hFF, '1);
        send_cmd(ctb_pkg::CMD_BACK, 8'h00, '0);
        send_cmd(ctb_pkg::CMD_READ, 8'h00, '0);
        send_cmd(ctb_pkg::CMD_READ, 8'hFF, '1);
        for (int c = CMD_UNDEF_FIRST; c <= CMD_UNDEF_LAST; c++)
            send_cmd(ctb_pkg::CMD_W'(c), 8'hFF, '1);
        // extreme bytes and the text constants
        send_cmd(ctb_pkg::CMD_INSERT, 8'h00, '0);
        send_cmd(ctb_pkg::CMD_INSERT, 8'hFF, '1);
        send_cmd(ctb_pkg::CMD_INSERT, "L", '0);
        send_cmd(ctb_pkg::CMD_INSERT, "D", '0);
        send_cmd(ctb_pkg::CMD_INSERT, "B", '0);
        send_cmd(ctb_pkg::CMD_INSERT, "P", '0);
        // insert in the middle of the text
        send_cmd(ctb_pkg::CMD_LEFT, 8'h00, '0);
        send_cmd(ctb_pkg::CMD_LEFT, 8'h00, '0);
        send_cmd(ctb_pkg::CMD_INSERT, 8'hA5, '0);
        // right runs into the end of text
        repeat (3) send_cmd(ctb_pkg::CMD_RIGHT, 8'h00, '0);
        send_cmd(ctb_pkg::CMD_READ, 8'h00, 10'd2);
        send_cmd(ctb_pkg::CMD_READ, 8'h00, 10'd7);
        // backspace in the middle
        send_cmd(ctb_pkg::CMD_LEFT, 8'h00, '0);
        send_cmd(ctb_pkg::CMD_BACK, 8'h00, '0);

        // random editing with a long receiver stall part way through
        run_random(200, 80);
        // sender pause until the editor has answered everything
        wait_all_results();
        @(negedge i_clk);
        fill_and_shrink();
        run_random(100, -1);
        // last stretch without idling on either side
        quiet = 1'b1;
        run_random(80, -1);
        i_in_valid = 1'b0;

        // drain, then allow for a worst-case shift still running
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DEPTH + 8) @(negedge i_clk);
        if (sb.pending() != 0)
            $error("%0d expected results never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** cursor_text_buffer: PASSED **");
        else
            $display("** cursor_text_buffer: FAILED **");
        $finish;
    end

endmodule
